>>> rtl/upv_pkg.sv
// types, constants and helper functions shared by the path validator modules
package upv_pkg;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;

    // dot-dot matcher: none, "/", "/.", "/.."
    typedef enum logic [1:0] {
        SUF_NONE   = 2'd0,
        SUF_SLASH  = 2'd1,
        SUF_DOT    = 2'd2,
        SUF_DOTDOT = 2'd3
    } t_suffix;

    // percent escape progress
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_escape;

    typedef struct packed {
        logic       seen_first;
        logic       rejected;
        t_suffix    raw_suffix;
        t_suffix    decoded_suffix;
        t_escape    escape_phase;
        logic [3:0] high_nibble;
    } t_upv_state;

    localparam t_upv_state STATE_RESET = '{
        seen_first:     1'b0,
        rejected:       1'b0,
        raw_suffix:     SUF_NONE,
        decoded_suffix: SUF_NONE,
        escape_phase:   ESC_NONE,
        high_nibble:    4'd0
    };

    // one item held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] path_byte;
        logic       is_last;
    } t_upv_item;

    typedef struct packed {
        logic    hit;
        t_suffix suffix;
    } t_suffix_step;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_suffix_step suffix_next(input t_suffix s, input logic [7:0] b);
        t_suffix_step r;
        r.hit    = 1'b0;
        r.suffix = SUF_NONE;
        if (b == CH_SLASH) begin
            r.hit    = (s == SUF_DOTDOT);
            r.suffix = SUF_SLASH;
        end else if (b == CH_DOT) begin
            case (s)
                SUF_SLASH: r.suffix = SUF_DOT;
                SUF_DOT:   r.suffix = SUF_DOTDOT;
                default:   r.suffix = SUF_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic t_hex hex_digit(input logic [7:0] b);
        t_hex r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.value = 4'(b - 8'h37);
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/upv_in_stage.sv
// input register for path bytes with its ready logic
module upv_in_stage
    import upv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_consume,
    output t_upv_item  o_item
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_s_tready = !r_valid || i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
            r_last <= i_s_tlast;
        end
    end

    assign o_item = '{valid: r_valid, path_byte: r_byte, is_last: r_last};

endmodule

>>> rtl/upv_step.sv
// next-state logic for one path byte: prefix, control byte, escape and dot-dot checks
module upv_step
    import upv_pkg::*;
(
    input  t_upv_state i_state,
    input  logic [7:0] i_byte,
    output t_upv_state o_next,
    output logic       o_path_ok
);

    t_suffix_step raw_step;
    t_suffix_step dec_step;
    t_hex         hex;
    logic [7:0]   dec_byte;
    logic         hit;

    always_comb begin
        o_next   = i_state;
        hit      = 1'b0;
        raw_step = suffix_next(i_state.raw_suffix, i_byte);
        hex      = hex_digit(i_byte);
        dec_byte = {i_state.high_nibble, hex.value};
        dec_step = suffix_next(i_state.decoded_suffix, i_byte);

        // once rejected the state is frozen until the last byte
        if (!i_state.rejected) begin
            if (!i_state.seen_first && i_byte != CH_SLASH) begin
                o_next.rejected = 1'b1;
            end
            o_next.seen_first = 1'b1;
            if (i_byte < CH_SPACE || i_byte == CH_DEL) begin
                o_next.rejected = 1'b1;
            end
            o_next.raw_suffix = raw_step.suffix;
            hit = raw_step.hit;

            case (i_state.escape_phase)
                ESC_NONE: begin
                    if (i_byte == CH_PERCENT) begin
                        o_next.escape_phase = ESC_HIGH;
                    end else begin
                        o_next.decoded_suffix = dec_step.suffix;
                        hit = hit || dec_step.hit;
                    end
                end
                ESC_HIGH: begin
                    if (!hex.valid) begin
                        o_next.rejected = 1'b1;
                    end else begin
                        o_next.high_nibble  = hex.value;
                        o_next.escape_phase = ESC_LOW;
                    end
                end
                default: begin
                    if (!hex.valid) begin
                        o_next.rejected = 1'b1;
                    end else begin
                        dec_step              = suffix_next(i_state.decoded_suffix, dec_byte);
                        o_next.escape_phase   = ESC_NONE;
                        o_next.decoded_suffix = dec_step.suffix;
                        hit = hit || dec_step.hit;
                    end
                end
            endcase

            if (hit) begin
                o_next.rejected = 1'b1;
            end
        end

        o_path_ok = !o_next.rejected && o_next.escape_phase == ESC_NONE &&
                    o_next.raw_suffix != SUF_DOTDOT && o_next.decoded_suffix != SUF_DOTDOT;
    end

endmodule

>>> rtl/upv_out_stage.sv
// result register holding one verdict until the receiver takes it
module upv_out_stage
    import upv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_path_ok,
    output logic       o_free,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata
);

    logic r_valid;
    logic r_ok;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ok <= i_path_ok;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {7'd0, r_ok};

endmodule

>>> rtl/url_path_validator_top.sv
// top level of the request path validator
//
// usage
//   slave side: one path byte per item on i_s_tdata, i_s_tlast marks the final
//   byte of a path. a path is never empty, so every item carries a byte.
//   master side: one item per path, given on the item that carries tlast;
//   o_m_tdata bit 0 is 1 for an accepted path, 0 for a rejected one.
//   rejects: first byte not '/', any control byte (below 0x20 or 0x7f), a '%'
//   not followed by two hex digits, or "/../" inside / "/.." at the end of
//   either the raw or the percent-decoded text.
// timing
//   one item per cycle while no held verdict blocks a last byte. a byte goes
//   into the input register, the per-byte state update is combinational
//   logic from there, and the verdict lands in the result register, which
//   drives o_m_tvalid, once the result register is free.
// reset
//   synchronous, active low; clears both register valids and the path state.
// stalls
//   a held verdict only blocks the next last byte; ordinary bytes keep
//   flowing into the path state. s_tready drops once the input register holds
//   a last byte and the result register is full and not being taken.
module url_path_validator_top
    import upv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] path_byte
    input  logic       i_s_tlast,   // is_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] path_ok, [7:1] zero
);

    t_upv_item  item;
    t_upv_state r_state;
    t_upv_state n_state;
    t_upv_state step_next;
    logic       step_ok;
    logic       out_free;
    logic       consume;
    logic       verdict;

    // a byte moves on unless it is a last byte and the result slot is taken
    assign consume = item.valid && (!item.is_last || out_free);
    assign verdict = consume && item.is_last;

    upv_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_consume  (consume),
        .o_item     (item)
    );

    upv_step u_step (
        .i_state   (r_state),
        .i_byte    (item.path_byte),
        .o_next    (step_next),
        .o_path_ok (step_ok)
    );

    // path state clears itself after every verdict
    always_comb begin
        n_state = r_state;
        if (consume) begin
            n_state = item.is_last ? STATE_RESET : step_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    upv_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (verdict),
        .i_path_ok  (step_ok),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // state is back to idle after a verdict
    a_clear_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        verdict |=> r_state == STATE_RESET)
        else $error("path state not cleared after verdict");

    // a rejection sticks until the last byte
    a_reject_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.rejected && consume && !item.is_last) |=> r_state.rejected)
        else $error("rejected flag dropped mid path");

    // a blocked byte stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item.valid && !consume) |=> (item.valid && $stable(item.path_byte)))
        else $error("input register lost a blocked item");

    // a verdict is only loaded into a free result slot
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        verdict |-> out_free)
        else $error("verdict loaded over an untaken result");

endmodule

>>> tb/sv/url_path_validator_top_tb.sv
// self-checking testbench for the request path validator top level
module url_path_validator_top_tb;
    import upv_pkg::*;

    // percent escape digit lookup: anything that is not a hex digit maps here
    localparam logic [4:0] NOT_HEX = 5'd16;

    // idling mixes for the two sides of the block
    typedef enum int unsigned {
        IDLING_NONE     = 0,
        IDLING_SENDER   = 1,
        IDLING_RECEIVER = 2,
        IDLING_BOTH     = 3
    } t_idling;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] path_byte
    logic       i_s_tlast;   // is_last
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [0] path_ok, [7:1] zero

    // path verdict predictor and the queue of verdicts still owed by the block
    class path_verdicts;
        logic       seen_first;
        logic       rejected;
        t_suffix    raw_suffix;
        t_suffix    decoded_suffix;
        t_escape    escape_phase;
        logic [3:0] high_nibble;
        logic       verdicts_due[$];
        int unsigned errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            seen_first     = 1'b0;
            rejected       = 1'b0;
            raw_suffix     = SUF_NONE;
            decoded_suffix = SUF_NONE;
            escape_phase   = ESC_NONE;
            high_nibble    = 4'd0;
        endfunction

        // dot-dot matcher, flags a completed "/../"
        function t_suffix advance(t_suffix s, logic [7:0] b, inout logic hit);
            if (b == CH_SLASH) begin
                if (s == SUF_DOTDOT) hit = 1'b1;
                return SUF_SLASH;
            end
            if (b == CH_DOT) begin
                if (s == SUF_SLASH) return SUF_DOT;
                if (s == SUF_DOT) return SUF_DOTDOT;
            end
            return SUF_NONE;
        endfunction

        function logic [4:0] hex_value(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);       // 0-9
            if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 10);  // a-f
            if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 10);  // A-F
            return NOT_HEX;
        endfunction

        // returns 1 when the byte still mattered to the path state
        function logic note_byte(logic [7:0] b, logic last);
            logic       hit;
            logic       taken;
            logic       ok;
            logic [4:0] digit;
            hit   = 1'b0;
            taken = !rejected;
            if (!rejected) begin
                if (!seen_first && b != CH_SLASH) rejected = 1'b1;
                seen_first = 1'b1;
                if (b < CH_SPACE || b == CH_DEL) rejected = 1'b1;
                raw_suffix = advance(raw_suffix, b, hit);
                if (escape_phase == ESC_NONE) begin
                    if (b == CH_PERCENT) escape_phase = ESC_HIGH;
                    else decoded_suffix = advance(decoded_suffix, b, hit);
                end else begin
                    digit = hex_value(b);
                    if (digit == NOT_HEX) begin
                        rejected = 1'b1;
                    end else if (escape_phase == ESC_HIGH) begin
                        high_nibble  = digit[3:0];
                        escape_phase = ESC_LOW;
                    end else begin
                        escape_phase   = ESC_NONE;
                        decoded_suffix = advance(decoded_suffix, {high_nibble, digit[3:0]}, hit);
                    end
                end
                if (hit) rejected = 1'b1;
            end
            if (last) begin
                ok = !rejected && escape_phase == ESC_NONE &&
                     raw_suffix != SUF_DOTDOT && decoded_suffix != SUF_DOTDOT;
                verdicts_due.push_back(ok);
                clear();
            end
            return taken;
        endfunction

        function void check_verdict(logic [7:0] got);
            logic want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with none pending, expected none got %h", $time, got);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== {7'b0, want}) begin
                $display("%0t: verdict mismatch, expected %h got %h", $time, {7'b0, want}, got);
                errors++;
            end
        endfunction
    endclass

    path_verdicts sb = new();

    logic [7:0]  path_buf[$];         // bytes of the path being sent
    int unsigned items_counted = 0;   // bytes accepted by the block
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_request = 0;    // cycles of receiver hold-off asked for

    url_path_validator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(8 * 500_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic void set_idling(t_idling mode);
        case (mode)
            IDLING_SENDER: begin
                sender_idle_pct    = 61;
                receiver_stall_pct = 0;
            end
            IDLING_RECEIVER: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 61;
            end
            IDLING_BOTH: begin
                sender_idle_pct    = 12;
                receiver_stall_pct = 12;
            end
            default: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_hex();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'(8'h30 + v);
        // letters in either case
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    // bytes that break an escape, some sitting right next to the hex ranges
    function automatic logic [7:0] rand_non_hex();
        case ($urandom_range(0, 7))
            0: return 8'h67;   // 'g'
            1: return 8'h47;   // 'G'
            2: return 8'h3A;   // just above '9'
            3: return 8'h40;   // just below 'A'
            4: return 8'h60;   // just below 'a'
            5: return CH_SLASH;
            6: return CH_PERCENT;
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    // one piece of a plausible path, weighted towards slashes, dots and escapes
    function automatic void push_token();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: path_buf.push_back(CH_SLASH);
            2, 3: path_buf.push_back(CH_DOT);
            4: begin
                // encoded dot
                path_buf.push_back(CH_PERCENT);
                path_buf.push_back(8'h32);
                path_buf.push_back($urandom_range(0, 1) ? 8'h65 : 8'h45);
            end
            5: begin
                // encoded slash
                path_buf.push_back(CH_PERCENT);
                path_buf.push_back(8'h32);
                path_buf.push_back($urandom_range(0, 1) ? 8'h66 : 8'h46);
            end
            6: begin
                path_buf.push_back(CH_PERCENT);
                path_buf.push_back(rand_hex());
                path_buf.push_back(rand_hex());
            end
            7: begin
                c = 8'($urandom_range(8'h21, 8'h7E));
                if (c == CH_PERCENT) c = CH_DOT;
                path_buf.push_back(c);
            end
            8: path_buf.push_back(8'($urandom_range(8'h80, 8'hFF)));
            default: path_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
        endcase
    endfunction

    // mostly well-formed paths, some with one fault, the rest raw noise
    function automatic void make_random_path();
        int unsigned kind;
        int unsigned pos;
        path_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            repeat ($urandom_range(1, 8)) path_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        path_buf.push_back(CH_SLASH);
        repeat ($urandom_range(0, 10)) push_token();
        if (kind < 65) return;
        pos = $urandom_range(1, path_buf.size());
        case ($urandom_range(0, 3))
            0: path_buf.insert(pos, $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F)) : CH_DEL);
            1: begin
                // bad escape, with or without a good first digit
                path_buf.insert(pos, rand_non_hex());
                if ($urandom_range(0, 1)) path_buf.insert(pos, rand_hex());
                path_buf.insert(pos, CH_PERCENT);
            end
            2: begin
                // escape cut off by the end of the path
                path_buf.push_back(CH_PERCENT);
                if ($urandom_range(0, 1)) path_buf.push_back(rand_hex());
            end
            default: path_buf[0] = 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void load_text(string s);
        path_buf.delete();
        for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
    endfunction

    // offers one item and returns at the edge where it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        logic ready;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        // ready is settled by the falling edge, so sample it there
        do begin
            @(negedge i_clk);
            ready = o_s_tready;
            @(posedge i_clk);
        end while (ready !== 1'b1);
        void'(sb.note_byte(b, last));
        items_counted++;
    endtask

    task automatic send_path();
        for (int i = 0; i < path_buf.size(); i++) send_byte(path_buf[i], i == path_buf.size() - 1);
    endtask

    // receiver: random stalls per phase, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // verdict monitor: handshake sampled at the falling edge, taken at the next rising one
    initial begin
        logic       take;
        logic [7:0] got;
        forever begin
            @(negedge i_clk);
            take = (o_m_tvalid === 1'b1) && (i_m_tready === 1'b1);
            got  = o_m_tdata;
            @(posedge i_clk);
            if (take) sb.check_verdict(got);
        end
    end

    // stimulus and end of run
    initial begin
        string directed_paths[$];
        logic  hold_done;
        hold_done = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tlast  <= 1'b0;
        set_idling(IDLING_NONE);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: shortest path, bad first byte with later bytes ignored,
        // top byte and raw delete, raw and encoded dot-dot, lowercase hex digits
        // with a decoded control byte and a decoded percent, bad escape,
        // escape cut off by the end, and a lone zero byte
        directed_paths = '{"/", "x/%", "/\377\177", "/..", "/.%2E/", "/%7f%25",
                           "/%G", "/%"};
        foreach (directed_paths[i]) begin
            load_text(directed_paths[i]);
            send_path();
        end
        send_byte(8'h00, 1'b1);

        // random part, cycling through the idling mixes
        while (items_counted < 1600) begin
            set_idling(t_idling'((items_counted / 160) % 4));
            if (!hold_done && items_counted >= 800) begin
                // long receiver hold-off so the block backs up into its input
                hold_request = 400;
                hold_done    = 1'b1;
            end
            make_random_path();
            send_path();
        end
        i_s_tvalid <= 1'b0;

        set_idling(IDLING_NONE);
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        // keep watching so a stray extra verdict would still be caught
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/upv_pkg.sv
rtl/upv_in_stage.sv
rtl/upv_step.sv
rtl/upv_out_stage.sv
rtl/url_path_validator_top.sv
tb/sv/url_path_validator_top_tb.sv
